FILE: rtl/cfrb_pkg.sv
// ----------------------------------------------------------------------------
// cfrb_pkg: shared types and constants of the command frame register bridge
// Frame marks, register map addresses and the records passed between the
// decoder and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrb_pkg;

    localparam logic [7:0]  SYNC_MARK     = 8'hEB;
    localparam logic [7:0]  KIND_WRITE    = 8'h90;
    localparam logic [7:0]  KIND_READ     = 8'h91;
    localparam logic [7:0]  TAIL_MARK     = 8'hEE;
    localparam logic [15:0] USER_LIMIT    = 16'h0400;
    localparam logic [15:0] BAD_ADDRESS   = 16'hEEEE;
    localparam logic [31:0] BAD_PAYLOAD   = 32'hEEEEEEEE;
    localparam logic [31:0] VERSION_RESET = 32'h20181112;

    // register map
    localparam logic [15:0] ADDR_VERSION   = 16'h8000;
    localparam logic [15:0] ADDR_LED_MODE  = 16'h8004;
    localparam logic [15:0] ADDR_TCP_ROUTE = 16'h8010;
    localparam logic [15:0] ADDR_TCP_RX    = 16'h8014;
    localparam logic [15:0] ADDR_TCP_TX    = 16'h8018;
    localparam logic [15:0] ADDR_TCP_CLEAR = 16'h801C;
    localparam logic [15:0] ADDR_UDP_ROUTE = 16'h8020;
    localparam logic [15:0] ADDR_UDP_RX    = 16'h8024;
    localparam logic [15:0] ADDR_UDP_TX    = 16'h8028;
    localparam logic [15:0] ADDR_UDP_CLEAR = 16'h802C;
    localparam logic [15:0] ADDR_TEST_A    = 16'h8030;
    localparam logic [15:0] ADDR_TEST_B    = 16'h8034;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  type_byte;
        logic [15:0] reg_address;
        logic [31:0] reg_value;
        logic [7:0]  tail_first;
        logic [7:0]  tail_second;
        logic [31:0] user_read_data;
        logic [31:0] tcp_rx_total;
        logic [31:0] tcp_tx_total;
        logic [31:0] udp_rx_total;
        logic [31:0] udp_tx_total;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  led_mode;
        logic [7:0]  tcp_route;
        logic [7:0]  udp_route;
        logic [7:0]  last_kind;
        logic [15:0] last_address;
        logic [31:0] last_payload;
    } bridge_state_t;

    typedef struct packed {
        logic [7:0]  reply_kind;
        logic [15:0] reply_address;
        logic [31:0] reply_payload;
        logic        user_write_strobe;
        logic [7:0]  user_word_index;
        logic [31:0] user_write_value;
        logic        tcp_count_clear;
        logic        udp_count_clear;
        logic [1:0]  led_mode_now;
        logic [7:0]  tcp_route_now;
        logic [7:0]  udp_route_now;
    } reply_t;

endpackage

`default_nettype wire

FILE: rtl/cfrb_if.sv
// ----------------------------------------------------------------------------
// cfrb_if: command and reply channels
// Valid/ready channels carrying one command frame word and one reply word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfrb_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sync_byte;
    logic [7:0]  type_byte;
    logic [15:0] reg_address;
    logic [31:0] reg_value;
    logic [7:0]  tail_first;
    logic [7:0]  tail_second;
    logic [31:0] user_read_data;
    logic [31:0] tcp_rx_total;
    logic [31:0] tcp_tx_total;
    logic [31:0] udp_rx_total;
    logic [31:0] udp_tx_total;

    modport source (
        output valid, sync_byte, type_byte, reg_address, reg_value, tail_first,
               tail_second, user_read_data, tcp_rx_total, tcp_tx_total,
               udp_rx_total, udp_tx_total,
        input  ready
    );

    modport sink (
        input  valid, sync_byte, type_byte, reg_address, reg_value, tail_first,
               tail_second, user_read_data, tcp_rx_total, tcp_tx_total,
               udp_rx_total, udp_tx_total,
        output ready
    );
endinterface

interface cfrb_reply_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_kind;
    logic [15:0] reply_address;
    logic [31:0] reply_payload;
    logic        user_write_strobe;
    logic [7:0]  user_word_index;
    logic [31:0] user_write_value;
    logic        tcp_count_clear;
    logic        udp_count_clear;
    logic [1:0]  led_mode_now;
    logic [7:0]  tcp_route_now;
    logic [7:0]  udp_route_now;

    modport source (
        output valid, reply_kind, reply_address, reply_payload, user_write_strobe,
               user_word_index, user_write_value, tcp_count_clear, udp_count_clear,
               led_mode_now, tcp_route_now, udp_route_now,
        input  ready
    );

    modport sink (
        input  valid, reply_kind, reply_address, reply_payload, user_write_strobe,
               user_word_index, user_write_value, tcp_count_clear, udp_count_clear,
               led_mode_now, tcp_route_now, udp_route_now,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/cfrb_decode.sv
// ----------------------------------------------------------------------------
// cfrb_decode: frame check and register map decode
// Checks the frame marks, decodes the address and forms the reply word and
// the next bridge state for one command word.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrb_decode
    import cfrb_pkg::*;
(
    input  wire cmd_t          cmd,
    input  wire bridge_state_t state_cur,
    input  wire [31:0]         version_word,
    output bridge_state_t      state_next,
    output reply_t             reply
);

    logic framed;
    logic user_hit;

    assign framed = (cmd.sync_byte == SYNC_MARK) && (cmd.tail_first == TAIL_MARK)
                 && (cmd.tail_second == TAIL_MARK);
    assign user_hit = (cmd.reg_address < USER_LIMIT) && (cmd.reg_address[1:0] == 2'b00);

    always_comb
    begin
        bridge_state_t nxt;
        logic          strobe;
        logic [7:0]    word_idx;
        logic [31:0]   wr_val;
        logic          tclr;
        logic          uclr;

        nxt      = state_cur;
        strobe   = 1'b0;
        word_idx = 8'd0;
        wr_val   = 32'd0;
        tclr     = 1'b0;
        uclr     = 1'b0;

        if (framed && cmd.type_byte == KIND_WRITE)
        begin
            nxt.last_kind    = KIND_WRITE;
            nxt.last_address = cmd.reg_address;
            nxt.last_payload = cmd.reg_value;
            unique case (cmd.reg_address)
                ADDR_LED_MODE:  nxt.led_mode  = cmd.reg_value[1:0];
                ADDR_TCP_ROUTE: nxt.tcp_route = cmd.reg_value[7:0];
                ADDR_TCP_CLEAR: tclr          = cmd.reg_value[0];
                ADDR_UDP_ROUTE: nxt.udp_route = cmd.reg_value[7:0];
                ADDR_UDP_CLEAR: uclr          = cmd.reg_value[0];
                ADDR_TEST_A, ADDR_TEST_B:
                begin
                    // echo only
                end
                default:
                begin
                    if (user_hit)
                    begin
                        strobe   = 1'b1;
                        word_idx = cmd.reg_address[9:2];
                        wr_val   = cmd.reg_value;
                    end
                    else
                    begin
                        nxt.last_address = BAD_ADDRESS;
                        nxt.last_payload = BAD_PAYLOAD;
                    end
                end
            endcase
        end
        else if (framed && cmd.type_byte == KIND_READ)
        begin
            nxt.last_kind    = KIND_READ;
            nxt.last_address = cmd.reg_address;
            unique case (cmd.reg_address)
                ADDR_VERSION:   nxt.last_payload = version_word;
                ADDR_LED_MODE:  nxt.last_payload = {30'd0, state_cur.led_mode};
                ADDR_TCP_ROUTE: nxt.last_payload = {24'd0, state_cur.tcp_route};
                ADDR_TCP_RX:    nxt.last_payload = cmd.tcp_rx_total;
                ADDR_TCP_TX:    nxt.last_payload = cmd.tcp_tx_total;
                ADDR_UDP_ROUTE: nxt.last_payload = {24'd0, state_cur.udp_route};
                ADDR_UDP_RX:    nxt.last_payload = cmd.udp_rx_total;
                ADDR_UDP_TX:    nxt.last_payload = cmd.udp_tx_total;
                default:
                begin
                    if (user_hit)
                    begin
                        word_idx         = cmd.reg_address[9:2];
                        nxt.last_payload = cmd.user_read_data;
                    end
                    else
                    begin
                        nxt.last_address = BAD_ADDRESS;
                        nxt.last_payload = BAD_PAYLOAD;
                    end
                end
            endcase
        end

        state_next               = nxt;
        reply.reply_kind         = nxt.last_kind;
        reply.reply_address      = nxt.last_address;
        reply.reply_payload      = nxt.last_payload;
        reply.user_write_strobe  = strobe;
        reply.user_word_index    = word_idx;
        reply.user_write_value   = wr_val;
        reply.tcp_count_clear    = tclr;
        reply.udp_count_clear    = uclr;
        reply.led_mode_now       = nxt.led_mode;
        reply.tcp_route_now      = nxt.tcp_route;
        reply.udp_route_now      = nxt.udp_route;
    end

endmodule

`default_nettype wire

FILE: rtl/command_frame_register_bridge.sv
// ----------------------------------------------------------------------------
// command_frame_register_bridge: command frame to register bridge
// Registers a command frame word, decodes it against the register map and
// holds the reply word in an output register.
// ----------------------------------------------------------------------------
// One frame word per cycle, sustained while the reply side keeps taking replies.
// A frame is held in the input register, with the frame check and map decode
// behind it, and its reply is offered from the reply register. The reply
// register and the input register move together, so a new frame is taken
// while a finished reply is still waiting as long as the reply side frees up
// in that cycle. A frame with bad marks repeats the previous reply's kind,
// address and payload, with no write strobe or clear (all zero after reset).
// Write the version word through cfg_wr_en/cfg_wr_data only while no frame
// is in flight; the block itself does not enforce this.
`default_nettype none

module command_frame_register_bridge
    import cfrb_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data,
    cfrb_cmd_if.sink    cmd,
    cfrb_reply_if.source reply
);

    cmd_t          cmd_reg;
    logic          cmd_valid_reg;
    reply_t        reply_reg;
    reply_t        reply_next;
    logic          reply_valid_reg;
    bridge_state_t state_reg;
    bridge_state_t state_next;
    logic [31:0]   version_reg;
    logic          out_free;
    logic          advance;
    cmd_t          cmd_in;

    assign out_free  = !reply_valid_reg || reply.ready;
    assign advance   = cmd_valid_reg && out_free;
    assign cmd.ready = !cmd_valid_reg || out_free;

    assign cmd_in.sync_byte      = cmd.sync_byte;
    assign cmd_in.type_byte      = cmd.type_byte;
    assign cmd_in.reg_address    = cmd.reg_address;
    assign cmd_in.reg_value      = cmd.reg_value;
    assign cmd_in.tail_first     = cmd.tail_first;
    assign cmd_in.tail_second    = cmd.tail_second;
    assign cmd_in.user_read_data = cmd.user_read_data;
    assign cmd_in.tcp_rx_total   = cmd.tcp_rx_total;
    assign cmd_in.tcp_tx_total   = cmd.tcp_tx_total;
    assign cmd_in.udp_rx_total   = cmd.udp_rx_total;
    assign cmd_in.udp_tx_total   = cmd.udp_tx_total;

    cfrb_decode u_decode (
        .cmd          (cmd_reg),
        .state_cur    (state_reg),
        .version_word (version_reg),
        .state_next   (state_next),
        .reply        (reply_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg   <= 1'b0;
            reply_valid_reg <= 1'b0;
            state_reg       <= '0;
            version_reg     <= VERSION_RESET;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (out_free)
            begin
                reply_valid_reg <= cmd_valid_reg;
            end
            // commit state only when the word moves into the reply register
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                version_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd_in;
        end
        if (advance)
        begin
            reply_reg <= reply_next;
        end
    end

    assign reply.valid             = reply_valid_reg;
    assign reply.reply_kind        = reply_reg.reply_kind;
    assign reply.reply_address     = reply_reg.reply_address;
    assign reply.reply_payload     = reply_reg.reply_payload;
    assign reply.user_write_strobe = reply_reg.user_write_strobe;
    assign reply.user_word_index   = reply_reg.user_word_index;
    assign reply.user_write_value  = reply_reg.user_write_value;
    assign reply.tcp_count_clear   = reply_reg.tcp_count_clear;
    assign reply.udp_count_clear   = reply_reg.udp_count_clear;
    assign reply.led_mode_now      = reply_reg.led_mode_now;
    assign reply.tcp_route_now     = reply_reg.tcp_route_now;
    assign reply.udp_route_now     = reply_reg.udp_route_now;

    // a user window write is always echoed as a write
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid_reg && reply_reg.user_write_strobe |-> reply_reg.reply_kind == KIND_WRITE)
        else $error("user write strobe on a non-write reply");

    // the two clear pulses come from different addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid_reg |-> !(reply_reg.tcp_count_clear && reply_reg.udp_count_clear))
        else $error("both counter clears in one reply");

    // bridge state changes only when a word advances
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("bridge state changed without an advancing word");

    // reported state matches the live state right after an advance
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> reply_reg.led_mode_now == state_reg.led_mode
                 && reply_reg.tcp_route_now == state_reg.tcp_route
                 && reply_reg.udp_route_now == state_reg.udp_route)
        else $error("reply state fields out of step with bridge state");

endmodule

`default_nettype wire
